### design/trq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and helper functions for the trackball core.
// No dependencies; imported by every trq_* module.
package trq_pkg;

	// datapath widths
	localparam int MW = 36;   // multiplier operand width (signed)
	localparam int PW = 72;   // product width
	localparam int SW = 64;   // radicand / dividend width
	localparam int RW = 32;   // root / divisor width
	localparam int ANG_BITS = 30;

	// parameter defaults
	localparam int DEF_CORDIC_STEPS  = 16;
	localparam int DEF_FRACTION_BITS = 14;

	// configuration register indexes
	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_WIDTH    = 3'd2;
	localparam logic [2:0] CFG_HEIGHT   = 3'd3;
	localparam logic [2:0] CFG_TOL      = 3'd4;

	localparam logic signed [MW-1:0] HALF_PI_ANG = 36'sd1686629713;
	localparam logic signed [MW-1:0] INV_GAIN    = 36'sd652032874;
	localparam logic signed [MW-1:0] ONE_ANG     = 36'sd1073741824;

	typedef logic signed [MW-1:0] word_t;

	// arctangent of 2^-i, radians scaled by 2^30, floored
	function automatic word_t atan_entry(input logic [4:0] i);
		word_t v;
		case (i)
			5'd0:  v = 36'sd843314856;
			5'd1:  v = 36'sd497837829;
			5'd2:  v = 36'sd263043836;
			5'd3:  v = 36'sd133525158;
			5'd4:  v = 36'sd67021686;
			5'd5:  v = 36'sd33543515;
			5'd6:  v = 36'sd16775850;
			5'd7:  v = 36'sd8388437;
			5'd8:  v = 36'sd4194282;
			5'd9:  v = 36'sd2097149;
			5'd10: v = 36'sd1048575;
			5'd11: v = 36'sd524287;
			5'd12: v = 36'sd262143;
			5'd13: v = 36'sd131071;
			5'd14: v = 36'sd65535;
			5'd15: v = 36'sd32767;
			5'd16: v = 36'sd16383;
			5'd17: v = 36'sd8191;
			5'd18: v = 36'sd4095;
			5'd19: v = 36'sd2047;
			5'd20: v = 36'sd1023;
			5'd21: v = 36'sd511;
			5'd22: v = 36'sd255;
			5'd23: v = 36'sd127;
			5'd24: v = 36'sd63;
			5'd25: v = 36'sd31;
			5'd26: v = 36'sd15;
			5'd27: v = 36'sd7;
			5'd28: v = 36'sd3;
			5'd29: v = 36'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// 2^30 scale to output scale: add half an LSB, floor shift, saturate to 16 bits
	function automatic logic [15:0] to_out(input word_t v, input int sh);
		logic signed [MW:0] rnd;
		logic signed [MW:0] s;
		rnd = (sh == 0) ? '0 : ((MW+1)'(1) <<< (sh - 1));
		s = ((MW+1)'(v) + rnd) >>> sh;
		if (s > 37'sd32767) return 16'h7FFF;
		else if (s < -37'sd32768) return 16'h8000;
		else return s[15:0];
	endfunction

	// magnitude at or above 2^30
	function automatic logic is_big(input word_t v);
		return (v >= 36'sd1073741824) || (v <= -36'sd1073741824);
	endfunction

endpackage

### design/trackball_rotation_quaternion_core.sv
`timescale 1ns / 1ps
// Virtual trackball core. An op 0 item lifts the pointer onto the view sphere and
// stores it as the drag start (no result); an op 1 item returns the rotation
// quaternion (w, x, y, z) in FRACTION_BITS fixed point from the start to the new
// point, or the identity with no_motion set when the move is within tolerance.
// One item is processed at a time and everything goes through shared bit-serial
// units: a multiplier, a square root, a divider and a CORDIC. A start item takes
// three products and at most one root; a roll item up to 18 products, two roots,
// two CORDIC passes and three divides, plus up to four normalizing shifts. The
// result sits in an output register, so a new item is accepted while it waits.
// Depends on trq_pkg, trq_mul, trq_sqrt, trq_div, trq_cordic.
module trackball_rotation_quaternion_core #(
	parameter int CORDIC_STEPS  = trq_pkg::DEF_CORDIC_STEPS,
	parameter int FRACTION_BITS = trq_pkg::DEF_FRACTION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // x_pos[14:0], y_pos[29:15], zero pad
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // quat_w, quat_x, quat_y, quat_z (16 bits each)
	output logic        m_axis_tuser,   // no_motion
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data
);
	import trq_pkg::*;

	localparam int SH = ANG_BITS - FRACTION_BITS;

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_MULW  = 4'd2;
	localparam logic [3:0] ST_LIFTZ = 4'd3;
	localparam logic [3:0] ST_SQRTW = 4'd4;
	localparam logic [3:0] ST_DEC   = 4'd5;
	localparam logic [3:0] ST_NORM  = 4'd6;
	localparam logic [3:0] ST_ANG   = 4'd7;
	localparam logic [3:0] ST_CORVW = 4'd8;
	localparam logic [3:0] ST_CORRW = 4'd9;
	localparam logic [3:0] ST_DIVW  = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	// product schedule
	localparam logic [4:0] K_XX  = 5'd0;
	localparam logic [4:0] K_YY  = 5'd1;
	localparam logic [4:0] K_RR  = 5'd2;
	localparam logic [4:0] K_C0A = 5'd3;
	localparam logic [4:0] K_C0B = 5'd4;
	localparam logic [4:0] K_C1A = 5'd5;
	localparam logic [4:0] K_C1B = 5'd6;
	localparam logic [4:0] K_C2A = 5'd7;
	localparam logic [4:0] K_C2B = 5'd8;
	localparam logic [4:0] K_D0  = 5'd9;
	localparam logic [4:0] K_D1  = 5'd10;
	localparam logic [4:0] K_D2  = 5'd11;
	localparam logic [4:0] K_S0  = 5'd12;
	localparam logic [4:0] K_S1  = 5'd13;
	localparam logic [4:0] K_S2  = 5'd14;
	localparam logic [4:0] K_Q0  = 5'd15;
	localparam logic [4:0] K_Q1  = 5'd16;
	localparam logic [4:0] K_Q2  = 5'd17;

	// configuration registers
	logic [12:0] org_x_q, org_y_q;
	logic [13:0] wid_q, hgt_q;
	logic [7:0]  tol_q;

	// control
	logic [3:0] state_q;
	logic [4:0] k_q;
	logic       op_q;
	logic       nm_q;
	logic       mv_q;
	logic       mul_go_q, sqrt_go_q, div_go_q, cor_go_q;

	// datapath
	logic signed [17:0] dx_q, dy_q, sdx_q, sdy_q;
	logic [13:0]        r_q, dz_q, sdz_q;
	logic signed [65:0] acc_q;
	word_t              c0_q, c1_q, c2_q, d_q, wv_q, sn_q;
	word_t              t_q [3];
	logic [RW-1:0]      cm_q;
	logic [SW-1:0]      sqrt_in_q;
	logic signed [SW-1:0] div_in_q;
	word_t              cx_q, cy_q, cz_q;
	logic               cvec_q;
	logic [63:0]        tdata_q;
	logic               tuser_q;

	// unit interfaces
	word_t              ma, mb, div_q, cor_x, cor_y, cor_z, cm_w;
	logic signed [PW-1:0] mul_p;
	logic               mul_done, sqrt_done, div_done, cor_done;
	logic [RW-1:0]      sqrt_root;
	logic [1:0]         qi;

	// input item fields and lifted coordinates
	logic signed [14:0] px, py;
	logic signed [18:0] dx_w, dy_w;
	logic signed [19:0] ddx, ddy;
	logic signed [19:0] tol2;
	logic               in_tol;

	always_comb begin
		px   = s_axis_tdata[14:0];
		py   = s_axis_tdata[29:15];
		dx_w = $signed({{3{px[14]}}, px, 1'b0}) - $signed({5'b0, org_x_q, 1'b0})
			- $signed({5'b0, wid_q});
		dy_w = $signed({5'b0, org_y_q, 1'b0}) + $signed({5'b0, hgt_q})
			- $signed({{3{py[14]}}, py, 1'b0});
		ddx  = 20'(dx_q) - 20'(sdx_q);
		ddy  = 20'(dy_q) - 20'(sdy_q);
		tol2 = $signed({11'b0, tol_q, 1'b0});
		in_tol = (ddx < tol2) && (-ddx < tol2) && (ddy < tol2) && (-ddy < tol2);
		cm_w = $signed({4'b0, cm_q});
		qi   = 2'(k_q - K_Q0);
	end

	// multiplier operand select
	always_comb begin
		case (k_q)
			K_XX:  begin ma = MW'(dx_q); mb = MW'(dx_q); end
			K_YY:  begin ma = MW'(dy_q); mb = MW'(dy_q); end
			K_RR:  begin ma = $signed({22'b0, r_q}); mb = $signed({22'b0, r_q}); end
			K_C0A: begin ma = MW'(sdy_q); mb = $signed({22'b0, dz_q}); end
			K_C0B: begin ma = $signed({22'b0, sdz_q}); mb = MW'(dy_q); end
			K_C1A: begin ma = $signed({22'b0, sdz_q}); mb = MW'(dx_q); end
			K_C1B: begin ma = MW'(sdx_q); mb = $signed({22'b0, dz_q}); end
			K_C2A: begin ma = MW'(sdx_q); mb = MW'(dy_q); end
			K_C2B: begin ma = MW'(sdy_q); mb = MW'(dx_q); end
			K_D0:  begin ma = MW'(sdx_q); mb = MW'(dx_q); end
			K_D1:  begin ma = MW'(sdy_q); mb = MW'(dy_q); end
			K_D2:  begin ma = $signed({22'b0, sdz_q}); mb = $signed({22'b0, dz_q}); end
			K_S0:  begin ma = c0_q; mb = c0_q; end
			K_S1:  begin ma = c1_q; mb = c1_q; end
			K_S2:  begin ma = c2_q; mb = c2_q; end
			K_Q0:  begin ma = sn_q; mb = c0_q; end
			K_Q1:  begin ma = sn_q; mb = c1_q; end
			K_Q2:  begin ma = sn_q; mb = c2_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	trq_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(ma), .b(mb),
		.done(mul_done), .prod(mul_p)
	);

	trq_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_go_q), .radicand(sqrt_in_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	trq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(div_in_q), .den(cm_q),
		.done(div_done), .quo(div_q)
	);

	trq_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_go_q), .vec_mode(cvec_q),
		.x0(cx_q), .y0(cy_q), .z0(cz_q),
		.done(cor_done), .x(cor_x), .y(cor_y), .z(cor_z)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			wid_q   <= 14'd640;
			hgt_q   <= 14'd480;
			tol_q   <= 8'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ORIGIN_X: org_x_q <= cfg_data[12:0];
				CFG_ORIGIN_Y: org_y_q <= cfg_data[12:0];
				CFG_WIDTH:    wid_q   <= cfg_data;
				CFG_HEIGHT:   hgt_q   <= cfg_data;
				CFG_TOL:      tol_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= K_XX;
			mv_q      <= 1'b0;
			mul_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			cor_go_q  <= 1'b0;
			sdx_q     <= '0;
			sdy_q     <= '0;
			sdz_q     <= '0;
		end else begin
			mul_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			cor_go_q  <= 1'b0;
			if (m_axis_tready) mv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= s_axis_tuser;
						dx_q    <= dx_w[17:0];
						dy_q    <= dy_w[17:0];
						r_q     <= (wid_q < hgt_q) ? wid_q : hgt_q;
						k_q     <= K_XX;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_go_q <= 1'b1;
					state_q  <= ST_MULW;
				end
				ST_MULW: begin
					if (mul_done) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_MUL;
						case (k_q)
							K_XX: acc_q <= 66'(mul_p);
							K_YY: acc_q <= acc_q + 66'(mul_p);
							K_RR: begin
								acc_q   <= 66'(mul_p) - acc_q;
								state_q <= ST_LIFTZ;
							end
							K_C0A: c0_q <= MW'(mul_p);
							K_C0B: c0_q <= c0_q - MW'(mul_p);
							K_C1A: c1_q <= MW'(mul_p);
							K_C1B: c1_q <= c1_q - MW'(mul_p);
							K_C2A: c2_q <= MW'(mul_p);
							K_C2B: c2_q <= c2_q - MW'(mul_p);
							K_D0:  d_q  <= MW'(mul_p);
							K_D1:  d_q  <= d_q + MW'(mul_p);
							K_D2: begin
								d_q     <= d_q + MW'(mul_p);
								state_q <= ST_NORM;
							end
							K_S0: acc_q <= 66'(mul_p);
							K_S1: acc_q <= acc_q + 66'(mul_p);
							K_S2: begin
								sqrt_in_q <= SW'(acc_q + 66'(mul_p));
								sqrt_go_q <= 1'b1;
								k_q       <= k_q;
								state_q   <= ST_SQRTW;
							end
							default: begin
								// quaternion vector part: product then divide by |c|
								div_in_q <= mul_p[SW-1:0];
								div_go_q <= 1'b1;
								k_q      <= k_q;
								state_q  <= ST_DIVW;
							end
						endcase
					end
				end
				// sphere height: zero outside the sphere
				ST_LIFTZ: begin
					k_q <= K_RR;
					if (acc_q[65]) begin
						dz_q    <= '0;
						state_q <= ST_DEC;
					end else begin
						sqrt_in_q <= acc_q[SW-1:0];
						sqrt_go_q <= 1'b1;
						state_q   <= ST_SQRTW;
					end
				end
				ST_SQRTW: begin
					if (sqrt_done) begin
						if (k_q == K_RR) begin
							dz_q    <= sqrt_root[13:0];
							state_q <= ST_DEC;
						end else begin
							cm_q    <= sqrt_root;
							state_q <= ST_ANG;
						end
					end
				end
				ST_DEC: begin
					if (!op_q) begin
						sdx_q   <= dx_q;
						sdy_q   <= dy_q;
						sdz_q   <= dz_q;
						state_q <= ST_IDLE;
					end else if (in_tol) begin
						wv_q    <= ONE_ANG;
						t_q[0]  <= '0;
						t_q[1]  <= '0;
						t_q[2]  <= '0;
						nm_q    <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						nm_q    <= 1'b0;
						k_q     <= K_C0A;
						state_q <= ST_MUL;
					end
				end
				// scale cross and dot products together below 2^30
				ST_NORM: begin
					if (is_big(c0_q) || is_big(c1_q) || is_big(c2_q) || is_big(d_q)) begin
						c0_q <= c0_q >>> 1;
						c1_q <= c1_q >>> 1;
						c2_q <= c2_q >>> 1;
						d_q  <= d_q >>> 1;
					end else begin
						k_q     <= K_S0;
						state_q <= ST_MUL;
					end
				end
				// angle = atan2(|c|, d); quarter-turn pre-rotation for a negative dot
				ST_ANG: begin
					cor_go_q <= 1'b1;
					if (cm_q == '0 && !d_q[MW-1]) begin
						cvec_q  <= 1'b0;
						cx_q    <= INV_GAIN;
						cy_q    <= '0;
						cz_q    <= '0;
						state_q <= ST_CORRW;
					end else begin
						cvec_q <= 1'b1;
						if (d_q[MW-1]) begin
							cx_q <= cm_w;
							cy_q <= -d_q;
							cz_q <= HALF_PI_ANG;
						end else begin
							cx_q <= d_q;
							cy_q <= cm_w;
							cz_q <= '0;
						end
						state_q <= ST_CORVW;
					end
				end
				ST_CORVW: begin
					if (cor_done) begin
						cvec_q   <= 1'b0;
						cx_q     <= INV_GAIN;
						cy_q     <= '0;
						cz_q     <= cor_z >>> 1;
						cor_go_q <= 1'b1;
						state_q  <= ST_CORRW;
					end
				end
				ST_CORRW: begin
					if (cor_done) begin
						wv_q <= cor_x;
						sn_q <= cor_y;
						if (cm_q == '0) begin
							t_q[0]  <= '0;
							t_q[1]  <= '0;
							t_q[2]  <= '0;
							state_q <= ST_FIN;
						end else begin
							k_q     <= K_Q0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						t_q[qi] <= div_q;
						if (k_q == K_Q2) begin
							state_q <= ST_FIN;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				// load the output register once it is free
				ST_FIN: begin
					if (!mv_q || m_axis_tready) begin
						tdata_q <= {to_out(t_q[2], SH), to_out(t_q[1], SH),
							to_out(t_q[0], SH), to_out(wv_q, SH)};
						tuser_q <= nm_q;
						mv_q    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = mv_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;
	assign cfg_ready     = 1'b1;

endmodule

### design/trq_mul.sv
`timescale 1ns / 1ps
// Bit-serial signed multiplier: one multiplier bit per cycle.
// Depends on trq_pkg.
module trq_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  trq_pkg::word_t             a,
	input  trq_pkg::word_t             b,
	output logic                       done,
	output logic signed [trq_pkg::PW-1:0] prod
);
	import trq_pkg::*;

	localparam int CW = $clog2(MW + 1);

	logic [PW-1:0] p_q;
	logic [MW-1:0] ma_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [MW:0]   sum;

	// add the multiplicand when the current multiplier bit is set
	always_comb begin
		sum = {1'b0, p_q[PW-1:MW]} + {1'b0, (p_q[0] ? ma_q : {MW{1'b0}})};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[MW-1] ? MW'(-a) : MW'(a);
			p_q   <= {{MW{1'b0}}, (b[MW-1] ? MW'(-b) : MW'(b))};
			neg_q <= a[MW-1] ^ b[MW-1];
		end else if (busy_q) begin
			p_q <= {sum, p_q[MW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = neg_q ? -$signed(p_q) : $signed(p_q);

endmodule

### design/trq_sqrt.sv
`timescale 1ns / 1ps
// Floor integer square root, one base-4 digit per cycle.
// Depends on trq_pkg.
module trq_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [trq_pkg::SW-1:0]  radicand,
	output logic                    done,
	output logic [trq_pkg::RW-1:0]  root
);
	import trq_pkg::*;

	localparam int CW = $clog2(RW + 1);

	logic [SW-1:0] v_q, r_q, b_q, rb;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	always_comb begin
		rb = r_q + b_q;
		ge = v_q >= rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// digit recurrence
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			b_q <= SW'(1) << (SW - 2);
		end else if (busy_q) begin
			if (ge) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[RW-1:0];

endmodule

### design/trq_div.sv
`timescale 1ns / 1ps
// Restoring signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on trq_pkg.
module trq_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [trq_pkg::SW-1:0] num,
	input  logic [trq_pkg::RW-1:0]  den,
	output logic                    done,
	output trq_pkg::word_t          quo
);
	import trq_pkg::*;

	localparam int CW = $clog2(SW + 1);

	logic [SW-1:0] n_q;
	logic [RW-1:0] rem_q, den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW:0]   tr;
	logic          fit;

	always_comb begin
		tr  = {rem_q, n_q[SW-1]};
		fit = tr >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-subtract on magnitudes; quotient shifts into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[SW-1] ? SW'(-num) : SW'(num);
			neg_q <= num[SW-1];
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? RW'(tr - {1'b0, den_q}) : tr[RW-1:0];
			n_q   <= {n_q[SW-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(n_q[MW-1:0]) : $signed(n_q[MW-1:0]);

endmodule

### design/trq_cordic.sv
`timescale 1ns / 1ps
// Shared CORDIC unit, vectoring or rotation mode, one iteration per cycle.
// Depends on trq_pkg (arctangent table).
module trq_cordic #(
	parameter int STEPS = trq_pkg::DEF_CORDIC_STEPS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           vec_mode,
	input  trq_pkg::word_t x0,
	input  trq_pkg::word_t y0,
	input  trq_pkg::word_t z0,
	output logic           done,
	output trq_pkg::word_t x,
	output trq_pkg::word_t y,
	output trq_pkg::word_t z
);
	import trq_pkg::*;

	localparam int CW = $clog2(STEPS + 1);

	word_t         x_q, y_q, z_q, xs, ys, at;
	logic          vec_q;
	logic [CW-1:0] cnt_q;
	logic [4:0]    idx;
	logic          busy_q;
	logic          done_q;
	logic          cw;

	// vectoring drives y to zero, rotation drives z to zero
	always_comb begin
		idx = 5'(cnt_q);
		xs  = x_q >>> idx;
		ys  = y_q >>> idx;
		at  = atan_entry(idx);
		cw  = vec_q ? (!y_q[MW-1] && (y_q != '0)) : z_q[MW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			vec_q <= vec_mode;
		end else if (busy_q) begin
			if (cw) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done = done_q;
	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

endmodule
